### rtl/core/smm_pkg.sv
// Shared types and constants of the segmented memory mapper.
// No dependencies; used by the interfaces and all core modules.
`timescale 1ns / 1ps

package smm_pkg;

	localparam int ADDR_W = 16;
	localparam int DATA_W = 8;
	localparam int PHYS_W = 19;

	localparam int PAGE_COUNT_DEF    = 8;
	localparam int SEGMENT_COUNT_DEF = 32;

	typedef enum logic [1:0] {
		OP_MEM_RD = 2'd0,
		OP_MEM_WR = 2'd1,
		OP_IO_RD  = 2'd2,
		OP_IO_WR  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		TGT_RAM  = 3'd0,
		TGT_ROM  = 3'd1,
		TGT_REG  = 3'd2,
		TGT_EXT  = 3'd3,
		TGT_NONE = 3'd4
	} target_t;

	// io port numbers, low address byte
	localparam logic [7:0] PORT_ID     = 8'h00;
	localparam logic [7:0] PORT_RAM0   = 8'h04;
	localparam logic [7:0] PORT_RAM1   = 8'h05;
	localparam logic [7:0] PORT_RAM2   = 8'h06;
	localparam logic [7:0] PORT_MAIN   = 8'h08;
	localparam logic [7:0] PORT_ROM2   = 8'h09;
	localparam logic [7:0] PORT_DISP   = 8'h0A;
	localparam logic [7:0] PORT_COMPAT = 8'hF9;
	localparam logic [7:0] PORT_COLOR  = 8'hFC;

	// full 16-bit external ports
	localparam logic [ADDR_W-1:0] PORT_EXT_A = 16'hFFFD;
	localparam logic [ADDR_W-1:0] PORT_EXT_B = 16'hBFFD;
	localparam logic [ADDR_W-1:0] PORT_EXT_C = 16'hBEFD;

	localparam logic [DATA_W-1:0] ID_BYTE    = 8'h56;
	localparam logic [DATA_W-1:0] DISP_RESET = 8'h50;
	localparam logic [DATA_W-1:0] NO_DATA    = 8'hFF;

	// dispatcher bit positions
	localparam int DISP_RAM0   = 0;
	localparam int DISP_RAM1   = 1;
	localparam int DISP_RAM2   = 2;
	localparam int DISP_ROM2   = 3;
	localparam int DISP_ROM1   = 4;
	localparam int DISP_FIXF0  = 6;
	localparam int DISP_COMPAT = 7;

	// compat top area, high address byte
	localparam logic [7:0] HI_F4_END = 8'hF4;
	localparam logic [7:0] HI_F8_END = 8'hF8;
	localparam logic [7:0] HI_HOLE   = 8'hF6;
	localparam logic [7:0] HI_EXT_A  = 8'hF8;
	localparam logic [7:0] HI_PAGE   = 8'hF9;
	localparam logic [7:0] HI_EXT_B  = 8'hFA;
	localparam logic [7:0] HI_EXT_C  = 8'hFF;

	typedef struct packed {
		logic [DATA_W-1:0] ram0;
		logic [DATA_W-1:0] ram1;
		logic [DATA_W-1:0] ram2;
		logic [DATA_W-1:0] main_page;
		logic [DATA_W-1:0] compat_page;
		logic [DATA_W-1:0] rom2;
		logic [DATA_W-1:0] disp;
	} map_regs_t;

	typedef struct packed {
		target_t           target;
		logic [PHYS_W-1:0] phys;
		logic              compat_wr;
	} map_res_t;

endpackage

### rtl/core/smm_req_if.sv
// Request channel: one CPU bus access per transfer.
// Depends on smm_pkg.
`timescale 1ns / 1ps

interface smm_req_if;
	logic                        valid;
	logic                        ready;
	smm_pkg::opcode_t            opcode;
	logic [smm_pkg::ADDR_W-1:0]  address;
	logic [smm_pkg::DATA_W-1:0]  write_data;

	modport source (output valid, output opcode, output address, output write_data,
		input ready);
	modport sink (input valid, input opcode, input address, input write_data,
		output ready);
endinterface

### rtl/core/smm_rsp_if.sv
// Response channel: target class, physical offset and read byte.
// Depends on smm_pkg.
`timescale 1ns / 1ps

interface smm_rsp_if;
	logic                        valid;
	logic                        ready;
	smm_pkg::target_t            target;
	logic [smm_pkg::PHYS_W-1:0]  phys_addr;
	logic [smm_pkg::DATA_W-1:0]  read_data;

	modport source (output valid, output target, output phys_addr, output read_data,
		input ready);
	modport sink (input valid, input target, input phys_addr, input read_data,
		output ready);
endinterface

### rtl/core/smm_mem_map.sv
// Memory window translation: address to RAM/ROM offset and target class.
// Depends on smm_pkg; combinational, instantiated by the top level.
`timescale 1ns / 1ps

module smm_mem_map #(
	parameter int PAGE_COUNT    = smm_pkg::PAGE_COUNT_DEF,
	parameter int SEGMENT_COUNT = smm_pkg::SEGMENT_COUNT_DEF
) (
	input  logic                       wr,
	input  logic [smm_pkg::ADDR_W-1:0] address,
	input  smm_pkg::map_regs_t         regs,
	output smm_pkg::map_res_t          res
);

	localparam int PAGE_W = $clog2(PAGE_COUNT);
	localparam int SEG_W  = $clog2(SEGMENT_COUNT);
	localparam int PW     = smm_pkg::PHYS_W;

	typedef logic [PAGE_W-1:0] page_tab_t [256];
	typedef logic [SEG_W-1:0]  seg_tab_t  [256];

	function automatic page_tab_t build_page_tab();
		page_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = PAGE_W'(i % PAGE_COUNT);
		end
		return t;
	endfunction

	function automatic seg_tab_t build_seg_tab();
		seg_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = SEG_W'(i % SEGMENT_COUNT);
		end
		return t;
	endfunction

	localparam page_tab_t PAGE_TAB = build_page_tab();
	localparam seg_tab_t  SEG_TAB  = build_seg_tab();

	logic [7:0]    page_sel;
	logic [PW-1:0] pg_base;
	logic [PW-1:0] a_ext;
	logic [PW-1:0] a_low;
	logic [PW-1:0] ram0_off;
	logic [PW-1:0] ram1_off;
	logic [PW-1:0] ram2_off;
	logic [PW-1:0] rom2_off;
	logic [7:0]    hi;
	logic [7:0]    disp;

	assign disp     = regs.disp;
	assign hi       = address[15:8];
	assign page_sel = disp[smm_pkg::DISP_COMPAT] ? regs.compat_page : regs.main_page;
	assign pg_base  = PW'({PAGE_TAB[page_sel], 16'h0000});
	assign a_ext    = PW'(address);
	assign a_low    = PW'(address[13:0]);
	assign ram0_off = PW'({SEG_TAB[regs.ram0], 14'h0000}) + a_ext;
	assign ram1_off = PW'({SEG_TAB[regs.ram1], 14'h0000}) + a_low;
	assign ram2_off = PW'({SEG_TAB[regs.ram2], 14'h0000}) + a_low;
	assign rom2_off = PW'({regs.rom2[2:0], 13'h0000}) + a_ext;

	always_comb begin
		res.target    = smm_pkg::TGT_RAM;
		res.phys      = a_ext;
		res.compat_wr = 1'b0;
		if (address < 16'h2000) begin
			if (disp[smm_pkg::DISP_ROM1]) begin
				res.target = wr ? smm_pkg::TGT_NONE : smm_pkg::TGT_ROM;
			end else begin
				res.phys = disp[smm_pkg::DISP_RAM0] ? ram0_off : pg_base + a_ext;
			end
		end else if (address < 16'h4000) begin
			if (disp[smm_pkg::DISP_ROM2]) begin
				if (wr) begin
					res.target = smm_pkg::TGT_NONE;
				end else begin
					res.target = smm_pkg::TGT_ROM;
					res.phys   = rom2_off;
				end
			end else begin
				res.phys = disp[smm_pkg::DISP_RAM0] ? ram0_off : pg_base + a_ext;
			end
		end else if (address < 16'h8000) begin
			res.phys = disp[smm_pkg::DISP_RAM1] ? ram1_off : pg_base + a_ext;
		end else if (address < 16'hC000) begin
			res.phys = disp[smm_pkg::DISP_RAM2] ? ram2_off : pg_base + a_ext;
		end else if (address < 16'hF000) begin
			res.phys = pg_base + a_ext;
		end else if (disp[smm_pkg::DISP_COMPAT]) begin
			if (hi < smm_pkg::HI_F4_END) begin
				res.target = smm_pkg::TGT_RAM;
			end else if (hi < smm_pkg::HI_F8_END) begin
				res.target = (hi == smm_pkg::HI_HOLE) ? smm_pkg::TGT_NONE : smm_pkg::TGT_EXT;
			end else if (!wr) begin
				res.target = smm_pkg::TGT_RAM;
			end else if (hi == smm_pkg::HI_EXT_A || hi == smm_pkg::HI_EXT_B ||
				hi == smm_pkg::HI_EXT_C) begin
				res.target = smm_pkg::TGT_EXT;
			end else if (hi == smm_pkg::HI_PAGE) begin
				res.target    = smm_pkg::TGT_REG;
				res.compat_wr = 1'b1;
			end else begin
				res.target = smm_pkg::TGT_NONE;
			end
		end else begin
			res.phys = disp[smm_pkg::DISP_FIXF0] ? a_ext : pg_base + a_ext;
		end
	end

endmodule

### rtl/core/segmented_memory_mapper_with_ports.sv
// Top level of the segmented memory mapper: input stage, io port decode,
// mapping registers, result register. Depends on smm_pkg, smm_req_if,
// smm_rsp_if and smm_mem_map.
//
//   channel  dir  fields                               transfer
//   req      in   opcode, address, write_data          valid & ready
//   rsp      out  target, phys_addr, read_data         valid & ready
//
// One access per cycle sustained while rsp is not stalled; an access passes
// the input register, then the result register. Mapping registers update
// on the edge that moves an access into the result register, so the next
// access sees them. Reset clears the pipeline and loads the register reset
// values. A stalled rsp holds the result; req stays ready while the input
// stage is empty or moving on.
`timescale 1ns / 1ps

module segmented_memory_mapper_with_ports #(
	parameter int PAGE_COUNT    = smm_pkg::PAGE_COUNT_DEF,
	parameter int SEGMENT_COUNT = smm_pkg::SEGMENT_COUNT_DEF
) (
	input logic         clk,
	input logic         arst_n,
	smm_req_if.sink     req,
	smm_rsp_if.source   rsp
);

	logic                       valid_s1;
	smm_pkg::opcode_t           opcode_s1;
	logic [smm_pkg::ADDR_W-1:0] address_s1;
	logic [smm_pkg::DATA_W-1:0] data_s1;

	logic                       rsp_valid_q;
	smm_pkg::target_t           target_q;
	logic [smm_pkg::PHYS_W-1:0] phys_q;
	logic [smm_pkg::DATA_W-1:0] rdata_q;

	logic [7:0] ram0_q, ram1_q, ram2_q, main_q, compat_q, rom2_q, disp_q, color_q;

	smm_pkg::map_regs_t regs;
	smm_pkg::map_res_t  mres;

	logic                       adv;
	logic                       fire;
	logic                       io_wr;
	logic [7:0]                 lo;
	smm_pkg::target_t           tg;
	logic [smm_pkg::PHYS_W-1:0] ph;
	logic [smm_pkg::DATA_W-1:0] rd;

	assign adv       = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || adv;
	assign fire      = valid_s1 && adv;
	assign io_wr     = fire && (opcode_s1 == smm_pkg::OP_IO_WR);
	assign lo        = address_s1[7:0];

	assign regs = '{ram0: ram0_q, ram1: ram1_q, ram2: ram2_q, main_page: main_q,
		compat_page: compat_q, rom2: rom2_q, disp: disp_q};

	smm_mem_map #(
		.PAGE_COUNT   (PAGE_COUNT),
		.SEGMENT_COUNT(SEGMENT_COUNT)
	) u_mem_map (
		.wr     (opcode_s1 == smm_pkg::OP_MEM_WR),
		.address(address_s1),
		.regs   (regs),
		.res    (mres)
	);

	always_comb begin
		tg = smm_pkg::TGT_NONE;
		ph = smm_pkg::PHYS_W'(address_s1);
		rd = '0;
		case (opcode_s1)
			smm_pkg::OP_MEM_RD, smm_pkg::OP_MEM_WR: begin
				tg = mres.target;
				ph = mres.phys;
				if (opcode_s1 == smm_pkg::OP_MEM_RD && mres.target == smm_pkg::TGT_NONE) begin
					rd = smm_pkg::NO_DATA;
				end
			end
			smm_pkg::OP_IO_RD: begin
				tg = smm_pkg::TGT_REG;
				case (lo)
					smm_pkg::PORT_ID:   rd = smm_pkg::ID_BYTE;
					smm_pkg::PORT_RAM0: rd = ram0_q;
					smm_pkg::PORT_RAM1: rd = ram1_q;
					smm_pkg::PORT_RAM2: rd = ram2_q;
					smm_pkg::PORT_MAIN: rd = main_q;
					smm_pkg::PORT_ROM2: rd = rom2_q;
					smm_pkg::PORT_DISP: rd = disp_q;
					default: begin
						if ((lo inside {[8'h10:8'h13], [8'h18:8'h1B], [8'h28:8'h2B]}) ||
							address_s1 == smm_pkg::PORT_EXT_A) begin
							tg = smm_pkg::TGT_EXT;
						end else begin
							tg = smm_pkg::TGT_NONE;
							rd = smm_pkg::NO_DATA;
						end
					end
				endcase
			end
			smm_pkg::OP_IO_WR: begin
				tg = smm_pkg::TGT_REG;
				case (lo)
					smm_pkg::PORT_RAM0, smm_pkg::PORT_RAM1, smm_pkg::PORT_RAM2,
					smm_pkg::PORT_MAIN, smm_pkg::PORT_ROM2, smm_pkg::PORT_DISP,
					smm_pkg::PORT_COMPAT, smm_pkg::PORT_COLOR: tg = smm_pkg::TGT_REG;
					default: begin
						if ((lo inside {[8'h10:8'h14], [8'h18:8'h1B], [8'h28:8'h2B],
							8'hF8, 8'hFA, 8'hFE, 8'hFF}) ||
							address_s1 == smm_pkg::PORT_EXT_A ||
							address_s1 == smm_pkg::PORT_EXT_B ||
							address_s1 == smm_pkg::PORT_EXT_C) begin
							tg = smm_pkg::TGT_EXT;
						end else begin
							tg = smm_pkg::TGT_NONE;
						end
					end
				endcase
			end
			default: tg = smm_pkg::TGT_NONE;
		endcase
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			opcode_s1  <= req.opcode;
			address_s1 <= req.address;
			data_s1    <= req.write_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			target_q <= tg;
			phys_q   <= ph;
			rdata_q  <= rd;
		end
	end

	// mapping registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram0_q   <= '0;
			ram1_q   <= '0;
			ram2_q   <= '0;
			main_q   <= '0;
			compat_q <= '0;
			rom2_q   <= '0;
			disp_q   <= smm_pkg::DISP_RESET;
			color_q  <= '0;
		end else begin
			if (io_wr) begin
				case (lo)
					smm_pkg::PORT_RAM0:   ram0_q   <= data_s1;
					smm_pkg::PORT_RAM1:   ram1_q   <= data_s1;
					smm_pkg::PORT_RAM2:   ram2_q   <= data_s1;
					smm_pkg::PORT_MAIN:   main_q   <= data_s1;
					smm_pkg::PORT_ROM2:   rom2_q   <= data_s1;
					smm_pkg::PORT_DISP:   disp_q   <= data_s1;
					smm_pkg::PORT_COMPAT: compat_q <= data_s1;
					smm_pkg::PORT_COLOR:  color_q  <= data_s1;
					default: ;
				endcase
			end
			if (fire && opcode_s1 == smm_pkg::OP_MEM_WR && mres.compat_wr) begin
				compat_q <= data_s1;
			end
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.target    = target_q;
	assign rsp.phys_addr = phys_q;
	assign rsp.read_data = rdata_q;

	a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp.valid)
		else $error("accepted access did not reach the result register");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid_q |-> req.ready)
		else $error("input stalled with empty result register");

	a_disp_write: assert property (@(posedge clk) disable iff (!arst_n)
		io_wr && lo == smm_pkg::PORT_DISP |=> disp_q == $past(data_s1))
		else $error("dispatcher write lost");

	a_color_write: assert property (@(posedge clk) disable iff (!arst_n)
		io_wr && lo == smm_pkg::PORT_COLOR |=> color_q == $past(data_s1))
		else $error("pseudo color write lost");

	a_mem_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.target == smm_pkg::TGT_RAM || rsp.target == smm_pkg::TGT_ROM ||
		rsp.target == smm_pkg::TGT_EXT) |-> rsp.read_data == '0)
		else $error("memory or external result carries read data");

endmodule
